>>> rtl/bdq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdq_pkg
// Shared constants, codes and controller/datapath interface types for the
// bounded double-ended queue with search.
// ----------------------------------------------------------------------------
package bdq_pkg;

  // Default sizing
  localparam int DEPTH_DEF       = 16;
  localparam int VALUE_WIDTH_DEF = 32;

  // Fixed port widths
  localparam int OP_W     = 3;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;

  // Operation codes
  localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
  localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
  localparam logic [OP_W-1:0] OP_CONTAINS   = 3'd4;
  localparam logic [OP_W-1:0] OP_REMOVE     = 3'd5;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

  // Logical index that the store read port looks at
  typedef enum logic [1:0] {
    RD_IDX,
    RD_IDX1,
    RD_FRONT,
    RD_BACK
  } bdq_rd_sel_e;

  // Controller to datapath commands
  typedef struct packed {
    logic                load_req;
    logic                push_front;
    logic                push_back;
    logic                pop_front;
    logic                pop_back;
    logic                status_we;
    logic [STATUS_W-1:0] status;
    logic                set_found;
    logic                idx_clr;
    logic                idx_inc;
    logic                rd_en;
    bdq_rd_sel_e         rd_sel;
    logic                shift_wr;
    logic                dec_count;
    logic                cap_front;
    logic                out_load;
  } bdq_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic empty;
    logic full;
    logic match;
    logic idx_last;
    logic idx_next_last;
    logic out_free;
  } bdq_stat_t;

endpackage

>>> rtl/bounded_deque_with_search.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_deque_with_search
// Bounded double-ended queue in a ring store with contains and
// remove-first-match; one result per request.
// ----------------------------------------------------------------------------
// Usage:
//   Requests (operation_i, value_i) enter on in_valid_i/in_ready_o; results
//   (status, found, front/back value, count, empty flag) leave on
//   out_valid_o/out_ready_i. Each request yields exactly one result.
//   One request is worked at a time; in_ready_o is high only while the
//   sequencer is idle. Contains and remove scan from the front to the
//   first match; remove then moves each later entry one place toward the
//   front. The sequencer is ready for the next request in the cycle after
//   it loads a result.
//   The single read port of the ring store paces the scan and the shift:
//   each scan or shift step is one read followed by a compare or a write.
//   A finished result sits in the output register; the next request can be
//   taken while it waits. If the receiver stalls, the following result is
//   held in the sequencer until the output register frees.
//   Reset empties the queue (head and count cleared); store contents are
//   not cleared, and front/back report zero while the queue is empty.
// ----------------------------------------------------------------------------
module bounded_deque_with_search #(
  parameter int DEPTH       = bdq_pkg::DEPTH_DEF,
  parameter int VALUE_WIDTH = bdq_pkg::VALUE_WIDTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [bdq_pkg::OP_W-1:0]            operation_i,
  input  logic signed [bdq_pkg::VALUE_W-1:0]  value_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [bdq_pkg::STATUS_W-1:0]        status_o,
  output logic                                found_o,
  output logic signed [bdq_pkg::VALUE_W-1:0]  front_value_o,
  output logic signed [bdq_pkg::VALUE_W-1:0]  back_value_o,
  output logic [bdq_pkg::COUNT_W-1:0]         count_o,
  output logic                                is_empty_o
);

  bdq_pkg::bdq_cmd_t  cmd;
  bdq_pkg::bdq_stat_t stat;

  bdq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .operation_i (operation_i),
    .cmd_o       (cmd),
    .stat_i      (stat)
  );

  bdq_datapath #(
    .DEPTH       (DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .value_i       (value_i),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .status_o      (status_o),
    .found_o       (found_o),
    .front_value_o (front_value_o),
    .back_value_o  (back_value_o),
    .count_o       (count_o),
    .is_empty_o    (is_empty_o)
  );

endmodule

>>> rtl/bdq_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdq_datapath
// Ring store, head/count registers, scan index, read data register and the
// result register that faces the output channel.
// ----------------------------------------------------------------------------
module bdq_datapath #(
  parameter int DEPTH       = bdq_pkg::DEPTH_DEF,
  parameter int VALUE_WIDTH = bdq_pkg::VALUE_WIDTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic signed [bdq_pkg::VALUE_W-1:0]  value_i,
  input  bdq_pkg::bdq_cmd_t                   cmd_i,
  output bdq_pkg::bdq_stat_t                  stat_o,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [bdq_pkg::STATUS_W-1:0]        status_o,
  output logic                                found_o,
  output logic signed [bdq_pkg::VALUE_W-1:0]  front_value_o,
  output logic signed [bdq_pkg::VALUE_W-1:0]  back_value_o,
  output logic [bdq_pkg::COUNT_W-1:0]         count_o,
  output logic                                is_empty_o
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = CW + 1;
  localparam logic [SW-1:0] DEPTH_S = SW'(DEPTH);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
  localparam logic [AW-1:0] LAST_A  = AW'(DEPTH - 1);

  // Ring position of a logical index: one add, one compare-and-subtract
  function automatic logic [AW-1:0] ring_pos(input logic [AW-1:0] head,
                                             input logic [CW-1:0] lidx);
    logic [SW-1:0] sum;
    begin
      sum = SW'(head) + SW'(lidx);
      if (sum >= DEPTH_S) begin
        sum = sum - DEPTH_S;
      end
      ring_pos = sum[AW-1:0];
    end
  endfunction

  logic [VALUE_WIDTH-1:0] mem [DEPTH];

  logic [AW-1:0]          head_q, head_d;
  logic [CW-1:0]          count_q, count_d;
  logic [CW-1:0]          idx_q, idx_d;
  logic [VALUE_WIDTH-1:0] val_q;
  logic [VALUE_WIDTH-1:0] rd_data_q;
  logic [VALUE_WIDTH-1:0] front_q;
  logic [bdq_pkg::STATUS_W-1:0] st_q;
  logic                   found_q;

  logic                   out_valid_q;
  logic [bdq_pkg::STATUS_W-1:0] out_status_q;
  logic                   out_found_q;
  logic [VALUE_WIDTH-1:0] out_front_q;
  logic [VALUE_WIDTH-1:0] out_back_q;
  logic [CW-1:0]          out_count_q;

  logic [AW-1:0]          head_dec;
  logic [CW-1:0]          rd_lidx;
  logic [AW-1:0]          rd_addr;
  logic [AW-1:0]          wr_addr;
  logic [VALUE_WIDTH-1:0] wr_data;
  logic                   wr_en;
  logic                   cnt_zero;
  logic [SW-1:0]          idx_p1;
  logic [SW-1:0]          idx_p2;

  assign cnt_zero = (count_q == '0);
  assign head_dec = (head_q == '0) ? LAST_A : head_q - AW'(1);
  assign idx_p1   = SW'(idx_q) + SW'(1);
  assign idx_p2   = SW'(idx_q) + SW'(2);

  // Read address select
  always_comb begin
    case (cmd_i.rd_sel)
      bdq_pkg::RD_IDX:   rd_lidx = idx_q;
      bdq_pkg::RD_IDX1:  rd_lidx = idx_p1[CW-1:0];
      bdq_pkg::RD_FRONT: rd_lidx = '0;
      bdq_pkg::RD_BACK:  rd_lidx = count_q - CW'(1);
      default:           rd_lidx = '0;
    endcase
  end
  assign rd_addr = ring_pos(head_q, rd_lidx);

  // Write port: push front, push back, or one step of the shift
  always_comb begin
    wr_en   = cmd_i.push_front | cmd_i.push_back | cmd_i.shift_wr;
    wr_data = cmd_i.shift_wr ? rd_data_q : val_q;
    if (cmd_i.push_front) begin
      wr_addr = head_dec;
    end else if (cmd_i.shift_wr) begin
      wr_addr = ring_pos(head_q, idx_q);
    end else begin
      wr_addr = ring_pos(head_q, count_q);
    end
  end

  // Store
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd_i.rd_en) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  // Head, count and scan index
  always_comb begin
    head_d  = head_q;
    count_d = count_q;
    idx_d   = idx_q;
    if (cmd_i.push_front) begin
      head_d  = head_dec;
      count_d = count_q + CW'(1);
    end
    if (cmd_i.push_back) begin
      count_d = count_q + CW'(1);
    end
    if (cmd_i.pop_front) begin
      head_d  = ring_pos(head_q, CW'(1));
      count_d = count_q - CW'(1);
    end
    if (cmd_i.pop_back || cmd_i.dec_count) begin
      count_d = count_q - CW'(1);
    end
    if (cmd_i.idx_clr) begin
      idx_d = '0;
    end else if (cmd_i.idx_inc) begin
      idx_d = idx_p1[CW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      count_q <= '0;
      idx_q   <= '0;
    end else begin
      head_q  <= head_d;
      count_q <= count_d;
      idx_q   <= idx_d;
    end
  end

  // Per-request working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      val_q   <= VALUE_WIDTH'($unsigned(value_i));
      st_q    <= bdq_pkg::ST_DONE;
      found_q <= 1'b0;
    end else begin
      if (cmd_i.status_we) begin
        st_q <= cmd_i.status;
      end
      if (cmd_i.set_found) begin
        found_q <= 1'b1;
      end
    end
    if (cmd_i.cap_front) begin
      front_q <= rd_data_q;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_status_q <= st_q;
      out_found_q  <= found_q;
      out_count_q  <= count_q;
      out_front_q  <= cnt_zero ? '0 : front_q;
      out_back_q   <= cnt_zero ? '0 : rd_data_q;
    end
  end

  // Status back to the controller
  assign stat_o.empty         = cnt_zero;
  assign stat_o.full          = (count_q == DEPTH_C);
  assign stat_o.match         = (rd_data_q == val_q);
  assign stat_o.idx_last      = (idx_p1 >= SW'(count_q));
  assign stat_o.idx_next_last = (idx_p2 >= SW'(count_q));
  assign stat_o.out_free      = !out_valid_q || out_ready_i;

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign found_o       = out_found_q;
  assign front_value_o = bdq_pkg::VALUE_W'(out_front_q);
  assign back_value_o  = bdq_pkg::VALUE_W'(out_back_q);
  assign count_o       = bdq_pkg::COUNT_W'(out_count_q);
  assign is_empty_o    = (out_count_q == '0);

endmodule

>>> rtl/bdq_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdq_ctrl
// Sequencer: decodes the request, runs the search and the tail shift, then
// reads front and back and hands the result to the output register.
// ----------------------------------------------------------------------------
module bdq_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [bdq_pkg::OP_W-1:0]      operation_i,
  output bdq_pkg::bdq_cmd_t             cmd_o,
  input  bdq_pkg::bdq_stat_t            stat_i
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_EXEC     = 4'd1;
  localparam logic [3:0] S_SCAN_RD  = 4'd2;
  localparam logic [3:0] S_SCAN_CMP = 4'd3;
  localparam logic [3:0] S_SH_RD    = 4'd4;
  localparam logic [3:0] S_SH_WR    = 4'd5;
  localparam logic [3:0] S_RD_FRONT = 4'd6;
  localparam logic [3:0] S_RD_BACK  = 4'd7;
  localparam logic [3:0] S_DONE     = 4'd8;

  logic [3:0]               state_q, state_d;
  logic [bdq_pkg::OP_W-1:0] op_q, op_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      op_q    <= bdq_pkg::OP_PUSH_FRONT;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
    end
  end

  // Next state and command decode
  always_comb begin
    state_d    = state_q;
    op_d       = op_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.rd_sel = bdq_pkg::RD_IDX;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_req = 1'b1;
          op_d           = operation_i;
          state_d        = S_EXEC;
        end
      end
      S_EXEC: begin
        state_d = S_RD_FRONT;
        case (op_q)
          bdq_pkg::OP_PUSH_FRONT, bdq_pkg::OP_PUSH_BACK: begin
            if (stat_i.full) begin
              cmd_o.status_we = 1'b1;
              cmd_o.status    = bdq_pkg::ST_FULL;
            end else begin
              cmd_o.push_front = (op_q == bdq_pkg::OP_PUSH_FRONT);
              cmd_o.push_back  = (op_q == bdq_pkg::OP_PUSH_BACK);
            end
          end
          bdq_pkg::OP_POP_FRONT, bdq_pkg::OP_POP_BACK: begin
            if (stat_i.empty) begin
              cmd_o.status_we = 1'b1;
              cmd_o.status    = bdq_pkg::ST_EMPTY;
            end else begin
              cmd_o.pop_front = (op_q == bdq_pkg::OP_POP_FRONT);
              cmd_o.pop_back  = (op_q == bdq_pkg::OP_POP_BACK);
            end
          end
          bdq_pkg::OP_CONTAINS, bdq_pkg::OP_REMOVE: begin
            if (stat_i.empty) begin
              cmd_o.status_we = 1'b1;
              cmd_o.status    = bdq_pkg::ST_EMPTY;
            end else begin
              cmd_o.idx_clr = 1'b1;
              state_d       = S_SCAN_RD;
            end
          end
          default: begin
            // unknown operation: report state only
          end
        endcase
      end
      S_SCAN_RD: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = bdq_pkg::RD_IDX;
        state_d      = S_SCAN_CMP;
      end
      S_SCAN_CMP: begin
        if (stat_i.match) begin
          cmd_o.set_found = 1'b1;
          if (op_q == bdq_pkg::OP_REMOVE) begin
            if (stat_i.idx_last) begin
              // match at the back: nothing to shift
              cmd_o.dec_count = 1'b1;
              state_d         = S_RD_FRONT;
            end else begin
              state_d = S_SH_RD;
            end
          end else begin
            state_d = S_RD_FRONT;
          end
        end else if (stat_i.idx_last) begin
          state_d = S_RD_FRONT;
        end else begin
          cmd_o.idx_inc = 1'b1;
          state_d       = S_SCAN_RD;
        end
      end
      S_SH_RD: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = bdq_pkg::RD_IDX1;
        state_d      = S_SH_WR;
      end
      S_SH_WR: begin
        cmd_o.shift_wr = 1'b1;
        cmd_o.idx_inc  = 1'b1;
        if (stat_i.idx_next_last) begin
          cmd_o.dec_count = 1'b1;
          state_d         = S_RD_FRONT;
        end else begin
          state_d = S_SH_RD;
        end
      end
      S_RD_FRONT: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = bdq_pkg::RD_FRONT;
        state_d      = S_RD_BACK;
      end
      S_RD_BACK: begin
        cmd_o.cap_front = 1'b1;
        cmd_o.rd_en     = 1'b1;
        cmd_o.rd_sel    = bdq_pkg::RD_BACK;
        state_d         = S_DONE;
      end
      S_DONE: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

>>> tb/deque_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deque_checker
// Watches both request and result channels of the bounded deque. Each
// accepted request is run through a queue-based model of the deque to form
// the expected result. Each accepted result is compared field by field with
// the oldest expected result. Mismatch count and outstanding results go to
// the top.
// ----------------------------------------------------------------------------
module deque_checker
  import bdq_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  input  logic                       in_ready_i,
  input  logic [OP_W-1:0]            operation_i,
  input  logic signed [VALUE_W-1:0]  value_i,
  input  logic                       out_valid_i,
  input  logic                       out_ready_i,
  input  logic [STATUS_W-1:0]        status_i,
  input  logic                       found_i,
  input  logic signed [VALUE_W-1:0]  front_value_i,
  input  logic signed [VALUE_W-1:0]  back_value_i,
  input  logic [COUNT_W-1:0]         count_i,
  input  logic                       is_empty_i,
  output int                         fail_count_o = 0,
  output int                         pending_o = 0
);

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                found;
    logic [VALUE_W-1:0]  front_value;
    logic [VALUE_W-1:0]  back_value;
    logic [COUNT_W-1:0]  count;
    logic                is_empty;
  } deque_result_t;

  // Model contents, index 0 is the front
  logic [VALUE_W-1:0] deque_q[$];
  // Expected results, oldest first
  deque_result_t      awaited_q[$];

  // Apply one request to the model and return the result it should produce
  function automatic deque_result_t apply_request(input logic [OP_W-1:0] op,
                                                  input logic [VALUE_W-1:0] val);
    deque_result_t r;
    int            hit;
    r        = '0;
    r.status = ST_DONE;
    hit      = -1;
    case (op)
      OP_PUSH_FRONT, OP_PUSH_BACK: begin
        if (deque_q.size() >= DEPTH) r.status = ST_FULL;
        else if (op == OP_PUSH_FRONT) deque_q.push_front(val);
        else deque_q.push_back(val);
      end
      OP_POP_FRONT, OP_POP_BACK, OP_CONTAINS, OP_REMOVE: begin
        if (deque_q.size() == 0) begin
          r.status = ST_EMPTY;
        end else if (op == OP_POP_FRONT) begin
          void'(deque_q.pop_front());
        end else if (op == OP_POP_BACK) begin
          void'(deque_q.pop_back());
        end else begin
          // first match from the front only
          for (int i = 0; i < deque_q.size(); i++) begin
            if (hit < 0 && deque_q[i] == val) hit = i;
          end
          r.found = (hit >= 0);
          if (op == OP_REMOVE && hit >= 0) deque_q.delete(hit);
        end
      end
      default: ; // unused codes leave the deque alone
    endcase
    r.count    = COUNT_W'(deque_q.size());
    r.is_empty = (deque_q.size() == 0);
    if (deque_q.size() != 0) begin
      r.front_value = deque_q[0];
      r.back_value  = deque_q[deque_q.size()-1];
    end
    return r;
  endfunction

  // Predict on accepted requests, score accepted results
  always @(posedge clk_i) begin
    deque_result_t want;
    int            errs;
    errs = 0;
    if (rst_ni) begin
      if (in_valid_i && in_ready_i) awaited_q.push_back(apply_request(operation_i, value_i));
      if (out_valid_i && out_ready_i) begin
        if (awaited_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual status %0d count %0d",
                   $time, status_i, count_i);
          errs++;
        end else begin
          want = awaited_q.pop_front();
          if (status_i !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, status_i);
            errs++;
          end
          if (found_i !== want.found) begin
            $display("%0t: found expected %0b actual %0b", $time, want.found, found_i);
            errs++;
          end
          if (front_value_i !== want.front_value) begin
            $display("%0t: front_value expected %h actual %h",
                     $time, want.front_value, front_value_i);
            errs++;
          end
          if (back_value_i !== want.back_value) begin
            $display("%0t: back_value expected %h actual %h",
                     $time, want.back_value, back_value_i);
            errs++;
          end
          if (count_i !== want.count) begin
            $display("%0t: count expected %0d actual %0d", $time, want.count, count_i);
            errs++;
          end
          if (is_empty_i !== want.is_empty) begin
            $display("%0t: is_empty expected %0b actual %0b", $time, want.is_empty, is_empty_i);
            errs++;
          end
        end
      end
      fail_count_o <= fail_count_o + errs;
      pending_o    <= awaited_q.size();
    end
  end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for bounded_deque_with_search. A short directed pass
// covers empty and full rejection, extreme values, duplicates and unused
// codes; then bursts of fill-, drain-, search-heavy and mixed random requests
// run under three handshake idling profiles. Scoring is done by deque_checker.
// ----------------------------------------------------------------------------
module tb_top;
  import bdq_pkg::*;

  localparam int DEPTH        = DEPTH_DEF;
  localparam int DRAIN_CYCLES = 100;

  // Codes the block must ignore
  localparam logic [OP_W-1:0] OP_RSVD_A = 3'd6;
  localparam logic [OP_W-1:0] OP_RSVD_B = 3'd7;

  typedef enum int {
    FILL_HEAVY,
    DRAIN_HEAVY,
    SEARCH_HEAVY,
    EVEN_MIX
  } traffic_mode_e;

  logic                      clk_i       = 1'b0;
  logic                      rst_ni      = 1'b0;
  logic                      in_valid_i  = 1'b0;
  logic                      in_ready_o;
  logic [OP_W-1:0]           operation_i = '0;
  logic signed [VALUE_W-1:0] value_i     = '0;
  logic                      out_valid_o;
  logic                      out_ready_i = 1'b0;
  logic [STATUS_W-1:0]       status_o;
  logic                      found_o;
  logic signed [VALUE_W-1:0] front_value_o;
  logic signed [VALUE_W-1:0] back_value_o;
  logic [COUNT_W-1:0]        count_o;
  logic                      is_empty_o;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int fail_count;
  int pending_results;

  bounded_deque_with_search #(
    .DEPTH      (DEPTH),
    .VALUE_WIDTH(VALUE_WIDTH_DEF)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .operation_i  (operation_i),
    .value_i      (value_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .status_o     (status_o),
    .found_o      (found_o),
    .front_value_o(front_value_o),
    .back_value_o (back_value_o),
    .count_o      (count_o),
    .is_empty_o   (is_empty_o)
  );

  deque_checker #(.DEPTH(DEPTH)) u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .operation_i  (operation_i),
    .value_i      (value_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .status_i     (status_o),
    .found_i      (found_o),
    .front_value_i(front_value_o),
    .back_value_i (back_value_o),
    .count_i      (count_o),
    .is_empty_i   (is_empty_o),
    .fail_count_o (fail_count),
    .pending_o    (pending_results)
  );

  // 50 MHz clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Result side back-pressure
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Present one request and hold it until accepted; called at a rising edge
  task automatic send_request(input logic [OP_W-1:0] op, input logic [VALUE_W-1:0] val);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    operation_i <= op;
    value_i     <= val;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Small pool so searches hit and duplicates pile up, plus full-range values
  function automatic logic [VALUE_W-1:0] pick_value();
    case ($urandom_range(9))
      0:          return 32'h7FFF_FFFF;
      1:          return 32'h8000_0000;
      2:          return 32'hFFFF_FFFF;
      3, 4, 5, 6: return VALUE_W'($urandom_range(7));
      default:    return $urandom();
    endcase
  endfunction

  function automatic logic [OP_W-1:0] pick_op(input traffic_mode_e mode);
    int r;
    r = $urandom_range(99);
    if (r < 3) return r[0] ? OP_RSVD_A : OP_RSVD_B;
    r = $urandom_range(99);
    case (mode)
      FILL_HEAVY: begin
        if (r < 40) return OP_PUSH_FRONT;
        if (r < 75) return OP_PUSH_BACK;
        if (r < 85) return OP_CONTAINS;
        if (r < 91) return OP_REMOVE;
        if (r < 96) return OP_POP_FRONT;
        return OP_POP_BACK;
      end
      DRAIN_HEAVY: begin
        if (r < 13) return OP_PUSH_FRONT;
        if (r < 25) return OP_PUSH_BACK;
        if (r < 55) return OP_POP_FRONT;
        if (r < 85) return OP_POP_BACK;
        if (r < 93) return OP_CONTAINS;
        return OP_REMOVE;
      end
      SEARCH_HEAVY: begin
        if (r < 20) return OP_PUSH_FRONT;
        if (r < 35) return OP_PUSH_BACK;
        if (r < 60) return OP_CONTAINS;
        if (r < 85) return OP_REMOVE;
        if (r < 93) return OP_POP_FRONT;
        return OP_POP_BACK;
      end
      default: return OP_W'(r % (OP_REMOVE + 1));
    endcase
  endfunction

  // Random bursts; ignored codes do not count toward n
  task automatic run_random(input int n);
    int              sent;
    int              burst;
    traffic_mode_e   mode;
    logic [OP_W-1:0] op;
    sent  = 0;
    burst = 0;
    mode  = EVEN_MIX;
    while (sent < n) begin
      if (burst == 0) begin
        mode  = traffic_mode_e'($urandom_range(3));
        burst = $urandom_range(45, 15);
      end
      burst--;
      op = pick_op(mode);
      send_request(op, pick_value());
      if (op != OP_RSVD_A && op != OP_RSVD_B) sent++;
    end
  endtask

  // Stimulus and verdict
  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 33;
    recv_idle_pct = 55;

    // empty store rejects and an ignored code
    send_request(OP_POP_FRONT, '0);
    send_request(OP_CONTAINS, 32'h7FFF_FFFF);
    send_request(OP_REMOVE, '0);
    send_request(OP_RSVD_A, 32'h1234_5678);
    // fill to capacity with extremes and duplicates at both ends
    send_request(OP_PUSH_FRONT, 32'h7FFF_FFFF);
    send_request(OP_PUSH_BACK, 32'h8000_0000);
    for (int i = 0; i < DEPTH - 2; i++) begin
      send_request(i[0] ? OP_PUSH_FRONT : OP_PUSH_BACK, VALUE_W'(i % 5));
    end
    send_request(OP_PUSH_BACK, 32'hFFFF_FFFF);   // rejected, full
    send_request(OP_CONTAINS, 32'h8000_0000);    // present
    send_request(OP_CONTAINS, 32'hFFFF_FFFF);    // absent
    send_request(OP_REMOVE, 32'd2);              // first of three copies, mid-store shift
    send_request(OP_POP_BACK, '0);
    send_request(OP_POP_FRONT, '0);

    run_random(334);

    send_idle_pct = 55;
    recv_idle_pct = 33;
    run_random(333);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(333);

    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_results != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #20_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

>>> bounded_deque_with_search.f
rtl/bdq_pkg.sv
rtl/bdq_datapath.sv
rtl/bdq_ctrl.sv
rtl/bounded_deque_with_search.sv
tb/deque_checker.sv
tb/tb_top.sv
